// ----- sv/fixed_point_divide_16_16_defines.svh -----
// ---------------------------------------------------------------------------
// Fixed-point divider assertion macros
// Shared concurrent assertion forms for the divider's checks.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_DIVIDE_16_16_DEFINES_SVH
`define FIXED_POINT_DIVIDE_16_16_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/fpd_pkg.sv -----
// ---------------------------------------------------------------------------
// fpd_pkg
// Shared constants and types of the fixed-point divider.
// ---------------------------------------------------------------------------
`default_nettype none

package fpd_pkg;

   localparam int FPD_DATA_WIDTH = 32;
   localparam int FPD_FRAC_BITS  = 16;

   // Control that travels alongside each item through the pipeline
   typedef struct packed {
      logic valid;
      logic neg;
      logic sat;
   } fpd_ctl_type;

endpackage

`default_nettype wire

// ----- sv/fpd_prep.sv -----
// ---------------------------------------------------------------------------
// fpd_prep
// Two front stages: operand magnitudes and sign, then the saturation guard.
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_prep
   import fpd_pkg::*;
#(
   parameter int DATA_WIDTH = FPD_DATA_WIDTH,
   parameter int FRAC_BITS  = FPD_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire logic [DATA_WIDTH-1:0] dividend,
   input  wire logic [DATA_WIDTH-1:0] divisor,
   output fpd_ctl_type                ctl,
   output logic      [DATA_WIDTH-1:0] num,
   output logic      [DATA_WIDTH-1:0] den
);

   localparam int SAT_SHIFT = ((DATA_WIDTH - FRAC_BITS) >= 2) ?
                              (DATA_WIDTH - FRAC_BITS - 2) : 0;

   logic                  v1_ff;
   logic                  neg1_ff;
   logic [DATA_WIDTH-1:0] ma_ff;
   logic [DATA_WIDTH-1:0] mb_ff;
   logic [DATA_WIDTH-1:0] ma_in;
   logic [DATA_WIDTH-1:0] mb_in;
   fpd_ctl_type           ctl2_ff;
   logic [DATA_WIDTH-1:0] num2_ff;
   logic [DATA_WIDTH-1:0] den2_ff;

   // Most negative operand maps to 2^(DATA_WIDTH-1) as an unsigned magnitude
   assign ma_in = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
   assign mb_in = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff         <= in_valid;
         ctl2_ff.valid <= v1_ff;
      end
      if (adv) begin
         neg1_ff       <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
         ma_ff         <= ma_in;
         mb_ff         <= mb_in;
         ctl2_ff.neg   <= neg1_ff;
         ctl2_ff.sat   <= ((ma_ff >> SAT_SHIFT) >= mb_ff);
         num2_ff       <= ma_ff;
         den2_ff       <= mb_ff;
      end
   end

   assign ctl = ctl2_ff;
   assign num = num2_ff;
   assign den = den2_ff;

endmodule

`default_nettype wire

// ----- sv/fpd_cell.sv -----
// ---------------------------------------------------------------------------
// fpd_cell
// One restoring-division step: shift in a dividend bit, trial subtract,
// shift the quotient bit in.
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_cell
   import fpd_pkg::*;
#(
   parameter int DATA_WIDTH = FPD_DATA_WIDTH,
   parameter bit USE_NUM    = 1'b1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire fpd_ctl_type           up_ctl,
   input  wire logic [DATA_WIDTH-1:0] up_rem,
   input  wire logic [DATA_WIDTH-1:0] up_num,
   input  wire logic [DATA_WIDTH-1:0] up_quo,
   input  wire logic [DATA_WIDTH-1:0] up_den,
   output fpd_ctl_type                dn_ctl,
   output logic      [DATA_WIDTH-1:0] dn_rem,
   output logic      [DATA_WIDTH-1:0] dn_num,
   output logic      [DATA_WIDTH-1:0] dn_quo,
   output logic      [DATA_WIDTH-1:0] dn_den
);

   logic                  nbit;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;
   logic                  ge;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] num_in;
   fpd_ctl_type           ctl_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] num_ff;
   logic [DATA_WIDTH-1:0] quo_ff;
   logic [DATA_WIDTH-1:0] den_ff;

   // Past the integer bits of the scaled dividend only zeros shift in
   assign nbit   = USE_NUM ? up_num[DATA_WIDTH-1] : 1'b0;
   assign num_in = USE_NUM ? {up_num[DATA_WIDTH-2:0], 1'b0} : up_num;
   assign trial  = {up_rem, nbit};
   assign diff   = trial - {1'b0, up_den};
   assign ge     = (trial >= {1'b0, up_den});
   // The remainder stays below the divisor, so DATA_WIDTH bits hold it
   assign rem_in = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= up_ctl.valid;
      end
      if (adv) begin
         ctl_ff.neg <= up_ctl.neg;
         ctl_ff.sat <= up_ctl.sat;
         rem_ff     <= rem_in;
         num_ff     <= num_in;
         quo_ff     <= {up_quo[DATA_WIDTH-2:0], ge};
         den_ff     <= up_den;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_rem = rem_ff;
   assign dn_num = num_ff;
   assign dn_quo = quo_ff;
   assign dn_den = den_ff;

endmodule

`default_nettype wire

// ----- sv/fpd_out.sv -----
// ---------------------------------------------------------------------------
// fpd_out
// Final sign fix-up and saturation select into a two-entry result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module fpd_out
   import fpd_pkg::*;
#(
   parameter int DATA_WIDTH = FPD_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire fpd_ctl_type           up_ctl,
   input  wire logic [DATA_WIDTH-1:0] up_quo,
   output logic                       full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [DATA_WIDTH-1:0] rsp_quotient,
   output logic                       rsp_saturated
);

   localparam logic [DATA_WIDTH-1:0] SIGN_ONLY = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] POS_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic [DATA_WIDTH-1:0] res;
   logic                  push;
   logic                  pop;
   logic [DATA_WIDTH-1:0] data_ff [0:1];
   logic                  sat_ff  [0:1];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            cnt_ff;

   always_comb begin
      if (up_ctl.sat) begin
         res = up_ctl.neg ? SIGN_ONLY : POS_MAX;
      end else begin
         res = up_ctl.neg ? (~up_quo + 1'b1) : up_quo;
      end
   end

   assign push = adv && up_ctl.valid;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= res;
         sat_ff[wr_ptr_ff]  <= up_ctl.sat;
      end
   end

   assign full          = cnt_ff[1];
   assign rsp_valid     = (cnt_ff != 2'd0);
   assign rsp_quotient  = data_ff[rd_ptr_ff];
   assign rsp_saturated = sat_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- sv/fixed_point_divide_16_16.sv -----
// ---------------------------------------------------------------------------
// fixed_point_divide_16_16
// Signed fixed-point divider with saturation, one restoring step per cell.
// ---------------------------------------------------------------------------
// Usage:
//   Present dividend and divisor on the req_ channel; an item is taken at a
//   rising edge with req_valid high and req_stall low. Each item yields one
//   rsp_ item: the quotient truncated toward zero, or the extreme of the
//   result's sign with rsp_saturated set when |dividend| >> (DATA_WIDTH -
//   FRAC_BITS - 2) is not below |divisor| (zero divisor included).
//   Path: from acceptance to rsp_valid an item passes two front stages,
//   one cell per quotient bit, then the result queue.
//   Throughput: one item per clock while req_stall is low; the division
//   cells advance together unless held, and each cell holds one item.
//   Receiver stall: results collect in a two-entry queue; the chain keeps
//   accepting items until that queue is full and a finished item waits at
//   the end of the chain, then req_stall rises and the whole chain holds.
//   Reset: synchronous, clears all valid flags and the queue; in-flight
//   items are dropped. No configuration is needed.
// ---------------------------------------------------------------------------
`include "fixed_point_divide_16_16_defines.svh"
`default_nettype none

module fixed_point_divide_16_16
   import fpd_pkg::*;
#(
   parameter int DATA_WIDTH = FPD_DATA_WIDTH,
   parameter int FRAC_BITS  = FPD_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [DATA_WIDTH-1:0] req_dividend,
   input  wire logic [DATA_WIDTH-1:0] req_divisor,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [DATA_WIDTH-1:0] rsp_quotient,
   output logic                       rsp_saturated
);

   localparam int NSTEP     = DATA_WIDTH + FRAC_BITS;
   localparam int SAT_SHIFT = ((DATA_WIDTH - FRAC_BITS) >= 2) ?
                              (DATA_WIDTH - FRAC_BITS - 2) : 0;

   // Chain links: index 0 feeds the first cell, index NSTEP leaves the last
   fpd_ctl_type           ctl_w [0:NSTEP];
   logic [DATA_WIDTH-1:0] rem_w [0:NSTEP];
   logic [DATA_WIDTH-1:0] num_w [0:NSTEP];
   logic [DATA_WIDTH-1:0] quo_w [0:NSTEP];
   logic [DATA_WIDTH-1:0] den_w [0:NSTEP];
   logic                  adv;
   logic                  out_full;

   // Hold the chain only when a finished item has nowhere to go
   assign adv       = !(ctl_w[NSTEP].valid && out_full);
   assign req_stall = !adv;

   fpd_prep #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .dividend (req_dividend),
      .divisor  (req_divisor),
      .ctl      (ctl_w[0]),
      .num      (num_w[0]),
      .den      (den_w[0])
   );

   // Every item starts with an empty remainder and quotient
   assign rem_w[0] = '0;
   assign quo_w[0] = '0;

   // Cell k settles quotient bit NSTEP-1-k; the first DATA_WIDTH cells
   // consume the dividend magnitude, the rest shift in fraction zeros.
   for (genvar k = 0; k < NSTEP; k++) begin : g_cell
      fpd_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .USE_NUM    (k < DATA_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .up_ctl (ctl_w[k]),
         .up_rem (rem_w[k]),
         .up_num (num_w[k]),
         .up_quo (quo_w[k]),
         .up_den (den_w[k]),
         .dn_ctl (ctl_w[k+1]),
         .dn_rem (rem_w[k+1]),
         .dn_num (num_w[k+1]),
         .dn_quo (quo_w[k+1]),
         .dn_den (den_w[k+1])
      );
   end

   fpd_out #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .up_ctl        (ctl_w[NSTEP]),
      .up_quo        (quo_w[NSTEP]),
      .full          (out_full),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_quotient  (rsp_quotient),
      .rsp_saturated (rsp_saturated)
   );

   // A saturated result is always one of the two extremes
   `FPD_ASSERT_IMPL(a_sat_extreme, clock, reset,
      rsp_valid && rsp_saturated,
      (rsp_quotient == {1'b1, {(DATA_WIDTH-1){1'b0}}}) ||
      (rsp_quotient == {1'b0, {(DATA_WIDTH-1){1'b1}}}),
      "saturated result is not an extreme value")

   // With a nonzero guard shift the quotient's magnitude stays below 2^(DATA_WIDTH-2)
   `FPD_ASSERT_IMPL(a_quo_range, clock, reset,
      rsp_valid && !rsp_saturated && (SAT_SHIFT > 0),
      rsp_quotient[DATA_WIDTH-1] == rsp_quotient[DATA_WIDTH-2],
      "unsaturated quotient out of guarded range")

   // A hold happens only with a full queue, and the queue then still shows
   `FPD_ASSERT_NEXT(a_hold_keeps_rsp, clock, reset,
      req_stall && rsp_stall,
      rsp_valid && ctl_w[NSTEP].valid,
      "held chain lost its finished item")

endmodule

`default_nettype wire
